// ----- design/vwd_pkg.sv -----
// shared types, constants and register codes for the vertex weld block
package vwd_pkg;

  localparam int MAX_UNIQUE_DEF = 256;

  localparam int TOL_W   = 31;
  localparam int SCALE_W = 24;
  localparam int COORD_W = 32;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd3277;   // about 0.05 in q16.16
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;  // 1.0 in q8.16

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_WELD_TOL = 1'b0,
    CFG_SCALE    = 1'b1
  } vwd_cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      end_of_set;
  } vwd_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [7:0]                entry_index;
    logic                      is_new;
    logic                      table_full;
    logic [8:0]                unique_count;
  } vwd_out_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                      vld;
    logic                      found;
    logic                      is_new;
    logic                      eos;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vwd_tok_t;

endpackage

// ----- design/vertex_weld_dedup.sv -----
// top level of the vertex welder: cell chain, scaling stage and output register
//
//  channel   ports                             handshake
//  -------   -------------------------------   ------------------------------------
//  input     start, busy, in_item              taken when start=1 and busy=0
//  result    out_valid, out_item               one-cycle strobe, cannot be held off
//  config    cfg_we, cfg_idx, cfg_wdata        written when cfg_we=1, no wait
//
// an item walks the chain of MAX_UNIQUE cells one cell per clock, then passes
// the scale multiply register and the output register; busy drops at the
// edge where the result strobe rises, so a new item is taken only after the
// last one is through. reset (rst_n low, synchronous) empties the list and
// loads the register defaults; stored entries hold garbage until written.
// the receiver cannot stall, so results are never held back.
module vertex_weld_dedup #(
  parameter int MAX_UNIQUE = vwd_pkg::MAX_UNIQUE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  vwd_pkg::vwd_in_t            in_item,
  // result channel
  output logic                        out_valid,
  output vwd_pkg::vwd_out_t           out_item,
  // configuration port
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_idx,
  input  logic [vwd_pkg::TOL_W-1:0]   cfg_wdata
);

  localparam int IDX_W = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
  localparam int CNT_W = $clog2(MAX_UNIQUE + 1);

  // configuration registers
  logic [vwd_pkg::TOL_W-1:0]   tol_r;
  logic [vwd_pkg::SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= vwd_pkg::TOL_RESET;
      scale_r <= vwd_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      case (vwd_pkg::vwd_cfg_idx_t'(cfg_idx))
        vwd_pkg::CFG_WELD_TOL: tol_r   <= cfg_wdata;
        vwd_pkg::CFG_SCALE:    scale_r <= cfg_wdata[vwd_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // input accept and busy flag
  logic accept;
  logic busy_r, busy_nxt;
  logic a_vld_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (a_vld_r) begin
      busy_nxt = 1'b0;   // result register loads at this edge
    end
  end

  // number of stored entries, stable while a token is in the chain
  logic [CNT_W-1:0] count_r, count_nxt;

  // cell chain: token enters cell 0 at the accepting edge
  vwd_pkg::vwd_tok_t tok_in;
  vwd_pkg::vwd_tok_t tok_w [0:MAX_UNIQUE];
  logic [IDX_W-1:0]  idx_w [0:MAX_UNIQUE];

  always_comb begin
    tok_in.vld    = accept;
    tok_in.found  = 1'b0;
    tok_in.is_new = 1'b0;
    tok_in.eos    = in_item.end_of_set;
    tok_in.x      = in_item.coord_x;
    tok_in.y      = in_item.coord_y;
    tok_in.z      = in_item.coord_z;
  end
  assign tok_w[0] = tok_in;
  assign idx_w[0] = '0;

  for (genvar g = 0; g < MAX_UNIQUE; g++) begin : g_cell
    vwd_cell #(
      .CELL_IDX (g),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count_i (count_r),
      .tol_i   (tol_r),
      .tok_i   (tok_w[g]),
      .idx_i   (idx_w[g]),
      .tok_o   (tok_w[g+1]),
      .idx_o   (idx_w[g+1])
    );
  end

  // chain exit: token found nothing means the list was full
  vwd_pkg::vwd_tok_t tok_end;
  logic [CNT_W-1:0]  cnt_after;

  assign tok_end   = tok_w[MAX_UNIQUE];
  assign cnt_after = count_r + CNT_W'(tok_end.is_new);

  always_comb begin
    count_nxt = count_r;
    if (tok_end.vld) begin
      count_nxt = tok_end.eos ? '0 : cnt_after;
    end
  end

  // scale stage: multipliers register their products inside
  logic             a_new_r, a_full_r;
  logic [IDX_W-1:0] a_idx_r;
  logic [CNT_W-1:0] a_cnt_r;

  always_ff @(posedge clk) begin
    a_new_r  <= tok_end.is_new;
    a_full_r <= !tok_end.found;
    a_idx_r  <= tok_end.found ? idx_w[MAX_UNIQUE] : '0;
    a_cnt_r  <= cnt_after;
  end

  logic signed [vwd_pkg::COORD_W-1:0] sc_x, sc_y, sc_z;

  vwd_scale u_scale_x (.clk(clk), .coord_i(tok_end.x), .scale_i(scale_r), .res_o(sc_x));
  vwd_scale u_scale_y (.clk(clk), .coord_i(tok_end.y), .scale_i(scale_r), .res_o(sc_y));
  vwd_scale u_scale_z (.clk(clk), .coord_i(tok_end.z), .scale_i(scale_r), .res_o(sc_z));

  // index and count keep their low bits only when the list is wide
  logic [31:0] idx_ext, cnt_ext;
  assign idx_ext = 32'(a_idx_r);
  assign cnt_ext = 32'(a_cnt_r);

  vwd_pkg::vwd_out_t out_r, out_nxt;
  logic              out_valid_r;

  always_comb begin
    out_nxt.out_x        = sc_x;
    out_nxt.out_y        = sc_y;
    out_nxt.out_z        = sc_z;
    out_nxt.entry_index  = idx_ext[7:0];
    out_nxt.is_new       = a_new_r;
    out_nxt.table_full   = a_full_r;
    out_nxt.unique_count = cnt_ext[8:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      a_vld_r     <= tok_end.vld;
      out_valid_r <= a_vld_r;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (a_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- design/vwd_cell.sv -----
// one list entry: compares the passing token, appends it at the end of the list
module vwd_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 8,
  parameter int CNT_W    = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [CNT_W-1:0]          count_i,
  input  logic [vwd_pkg::TOL_W-1:0] tol_i,
  input  vwd_pkg::vwd_tok_t         tok_i,
  input  logic [IDX_W-1:0]          idx_i,
  output vwd_pkg::vwd_tok_t         tok_o,
  output logic [IDX_W-1:0]          idx_o
);

  logic signed [vwd_pkg::COORD_W-1:0] ent_x_r;
  logic signed [vwd_pkg::COORD_W-1:0] ent_y_r;
  logic signed [vwd_pkg::COORD_W-1:0] ent_z_r;

  vwd_pkg::vwd_tok_t tok_r, tok_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic in_list;
  logic at_end;
  logic searching;
  logic hit;
  logic app;

  // |a - b| < tol on one axis, 33-bit difference
  function automatic logic axis_near(input logic signed [31:0] a,
                                     input logic signed [31:0] b,
                                     input logic [30:0] tol);
    logic signed [32:0] d;
    logic [32:0]        mag;
    d   = {a[31], a} - {b[31], b};
    mag = d[32] ? 33'(-d) : 33'(d);
    return mag < {2'b00, tol};
  endfunction

  assign in_list   = CNT_W'(CELL_IDX) < count_i;
  assign at_end    = CNT_W'(CELL_IDX) == count_i;
  assign searching = tok_i.vld && !tok_i.found;
  assign hit = searching && in_list &&
               axis_near(tok_i.x, ent_x_r, tol_i) &&
               axis_near(tok_i.y, ent_y_r, tol_i) &&
               axis_near(tok_i.z, ent_z_r, tol_i);
  assign app = searching && at_end;

  always_comb begin
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.x     = ent_x_r;
      tok_nxt.y     = ent_y_r;
      tok_nxt.z     = ent_z_r;
      idx_nxt       = IDX_W'(CELL_IDX);
    end else if (app) begin
      tok_nxt.found  = 1'b1;
      tok_nxt.is_new = 1'b1;
      idx_nxt        = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
    idx_r <= idx_nxt;
  end

  // entry storage, written only on append
  always_ff @(posedge clk) begin
    if (app) begin
      ent_x_r <= tok_i.x;
      ent_y_r <= tok_i.y;
      ent_z_r <= tok_i.z;
    end
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule

// ----- design/vwd_scale.sv -----
// coordinate times q8.16 scale, floor to q16.16 and saturate to 32 bits
module vwd_scale (
  input  logic                               clk,
  input  logic signed [vwd_pkg::COORD_W-1:0] coord_i,
  input  logic [vwd_pkg::SCALE_W-1:0]        scale_i,
  output logic signed [vwd_pkg::COORD_W-1:0] res_o
);

  localparam int PROD_W = vwd_pkg::COORD_W + vwd_pkg::SCALE_W + 1;
  localparam int SHR_W  = PROD_W - 16;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [SHR_W-1:0]  shr;
  logic                     ovf;

  assign prod_nxt = PROD_W'(coord_i) * $signed({1'b0, scale_i});

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // arithmetic shift rounds toward minus infinity
  assign shr = prod_r[PROD_W-1:16];
  assign ovf = (shr[SHR_W-1:31] != {(SHR_W-31){shr[SHR_W-1]}});

  always_comb begin
    if (!ovf) begin
      res_o = shr[31:0];
    end else if (shr[SHR_W-1]) begin
      res_o = {1'b1, 31'd0};
    end else begin
      res_o = {1'b0, {31{1'b1}}};
    end
  end

endmodule
